### rtl/assert_macros.svh
// Assertion macros shared by the checker files.
// Both sample on clk; the first is gated off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define PWL_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Checked on every edge, reset included.
`define PWL_ASSERT_ANY(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/pwl_pkg.sv
// Shared widths, reset values, register codes and stage payload types
// for the piecewise linear calibration core. No dependencies.
package pwl_pkg;

  localparam int unsigned X_W       = 8;            // reading / breakpoint byte
  localparam int unsigned PCT_W     = 7;            // result percent
  localparam int unsigned SEG_W     = 3;            // segment index
  localparam int unsigned REG_W     = 64;           // packed point registers
  localparam int unsigned CFG_IDX_W = 2;            // config register index
  localparam int unsigned P_W       = 2 * X_W + 2;  // signed 9x9 product
  localparam int unsigned NUM_W     = 2 * X_W + 3;  // sum of two products
  localparam int unsigned MAG_W     = 2 * X_W + 1;  // |numerator|
  localparam int unsigned Q_W       = 8;            // quotient bits, top one flags overflow

  localparam logic [REG_W-1:0] RES_PTS_RST = 64'hAF8C81664B36140A;
  localparam logic [REG_W-1:0] PCT_PTS_RST = 64'h646054483C30180C;
  localparam logic [PCT_W-1:0] PCT_MAX     = 7'd100;
  localparam logic [PCT_W-1:0] PCT_MIN     = 7'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RES_POINTS = 2'd0,
    REG_PCT_POINTS = 2'd1
  } cfg_reg_t;

  // Segment select stage -> multiply stage
  typedef struct packed {
    logic signed [X_W:0] dx;
    logic signed [X_W:0] dy;
    logic signed [X_W:0] den;
    logic [X_W-1:0]      y0;
    logic [SEG_W-1:0]    lo;
    logic                flat;
  } seg_t;

  // Multiply stage -> sum stage
  typedef struct packed {
    logic signed [P_W-1:0] p0;
    logic signed [P_W-1:0] p1;
    logic                  den_neg;
    logic [X_W-1:0]        den_mag;
    logic [X_W-1:0]        y0;
    logic [SEG_W-1:0]      lo;
    logic                  flat;
  } prod_t;

  // Travels down the divider cell row
  typedef struct packed {
    logic [MAG_W-1:0] rem;
    logic [X_W-1:0]   den_mag;
    logic [Q_W-1:0]   q;
    logic             neg;
    logic [X_W-1:0]   y0;
    logic [SEG_W-1:0] lo;
    logic             flat;
  } div_t;

  // Final result beat
  typedef struct packed {
    logic [PCT_W-1:0] percent;
    logic [SEG_W-1:0] segment;
    logic             clamped;
    logic             flat_segment;
  } res_t;

endpackage

### rtl/pwl_ifs.sv
// Valid/ready channel interfaces: reading input, result output, config writes.
// Depends on pwl_pkg for field widths.
interface pwl_in_if import pwl_pkg::*; ();
  logic           valid;
  logic           ready;
  logic [X_W-1:0] resistance;

  modport source (output valid, output resistance, input ready);
  modport sink   (input valid, input resistance, output ready);
endinterface

interface pwl_out_if import pwl_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PCT_W-1:0] percent;
  logic [SEG_W-1:0] segment;
  logic             clamped;
  logic             flat_segment;

  modport source (output valid, output percent, output segment, output clamped,
                  output flat_segment, input ready);
  modport sink   (input valid, input percent, input segment, input clamped,
                  input flat_segment, output ready);
endinterface

interface pwl_cfg_if import pwl_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [REG_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/pwl_seg.sv
// Breakpoint search and segment select: one registered stage.
// Depends on pwl_pkg.
module pwl_seg import pwl_pkg::*; #(
  parameter int unsigned POINTS = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [REG_W-1:0] res_pts,
  input  logic [REG_W-1:0] pct_pts,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [X_W-1:0]   in_x,
  output logic             out_valid,
  input  logic             out_ready,
  output seg_t             out_seg
);

  logic             valid_r;
  seg_t             seg_r;
  seg_t             seg_nxt;
  logic [SEG_W-1:0] lo;
  logic [SEG_W-1:0] lo_p1;
  logic             run;
  logic [X_W-1:0]   x0, x1, y0, y1;

  // lo = (first breakpoint not below x) - 1, held to 0..POINTS-2
  always_comb begin
    lo  = '0;
    run = (in_x > res_pts[0 +: X_W]);
    for (int k = 1; k < int'(POINTS) - 1; k++) begin
      run = run && (in_x > res_pts[k*X_W +: X_W]);
      if (run) begin
        lo = SEG_W'(k);
      end
    end
  end

  // fetch segment end points and form the differences
  always_comb begin
    lo_p1 = lo + SEG_W'(1);
    x0    = res_pts[lo * X_W +: X_W];
    x1    = res_pts[lo_p1 * X_W +: X_W];
    y0    = pct_pts[lo * X_W +: X_W];
    y1    = pct_pts[lo_p1 * X_W +: X_W];
    seg_nxt.dx   = $signed({1'b0, in_x}) - $signed({1'b0, x0});
    seg_nxt.dy   = $signed({1'b0, y1}) - $signed({1'b0, y0});
    seg_nxt.den  = $signed({1'b0, x1}) - $signed({1'b0, x0});
    seg_nxt.y0   = y0;
    seg_nxt.lo   = lo;
    seg_nxt.flat = (x1 == x0);
  end

  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      seg_r <= seg_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_seg   = seg_r;

endmodule

### rtl/pwl_arith.sv
// Numerator build: multiply stage, then sum / sign / magnitude stage.
// Depends on pwl_pkg. Feeds the divider cell row.
module pwl_arith import pwl_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  seg_t in_seg,
  output logic out_valid,
  input  logic out_ready,
  output div_t out_div
);

  logic                  mul_valid_r;
  prod_t                 prod_r;
  prod_t                 prod_nxt;
  logic                  mul_ready;
  logic                  sum_valid_r;
  div_t                  div_r;
  div_t                  div_nxt;
  logic signed [X_W:0]   den_abs;
  logic signed [NUM_W-1:0] num;
  logic signed [NUM_W-1:0] num_abs;

  // y0*den and dy*dx, 9x9 signed each
  always_comb begin
    den_abs          = in_seg.den[X_W] ? -in_seg.den : in_seg.den;
    prod_nxt.p0      = $signed({1'b0, in_seg.y0}) * in_seg.den;
    prod_nxt.p1      = in_seg.dy * in_seg.dx;
    prod_nxt.den_neg = in_seg.den[X_W];
    prod_nxt.den_mag = den_abs[X_W-1:0];
    prod_nxt.y0      = in_seg.y0;
    prod_nxt.lo      = in_seg.lo;
    prod_nxt.flat    = in_seg.flat;
  end

  // numerator, quotient sign and magnitude for the unsigned divider
  always_comb begin
    num             = NUM_W'(prod_r.p0) + NUM_W'(prod_r.p1);
    num_abs         = num[NUM_W-1] ? -num : num;
    div_nxt.rem     = num_abs[MAG_W-1:0];
    div_nxt.den_mag = prod_r.den_mag;
    div_nxt.q       = '0;
    div_nxt.neg     = num[NUM_W-1] ^ prod_r.den_neg;
    div_nxt.y0      = prod_r.y0;
    div_nxt.lo      = prod_r.lo;
    div_nxt.flat    = prod_r.flat;
  end

  assign mul_ready = !sum_valid_r || out_ready;
  assign in_ready  = !mul_valid_r || mul_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_valid_r <= 1'b0;
      sum_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        mul_valid_r <= in_valid;
      end
      if (mul_ready) begin
        sum_valid_r <= mul_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      prod_r <= prod_nxt;
    end
    if (mul_valid_r && mul_ready) begin
      div_r <= div_nxt;
    end
  end

  assign out_valid = sum_valid_r;
  assign out_div   = div_r;

endmodule

### rtl/pwl_div_cell.sv
// One restoring-divide cell: settles quotient bit SHIFT and hands on.
// Depends on pwl_pkg.
module pwl_div_cell import pwl_pkg::*; #(
  parameter int unsigned SHIFT = 0
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  div_t in_div,
  output logic out_valid,
  input  logic out_ready,
  output div_t out_div
);

  logic             valid_r;
  div_t             div_r;
  div_t             div_nxt;
  logic [MAG_W-1:0] trial;

  // compare against den << SHIFT, subtract on success
  always_comb begin
    trial   = MAG_W'(in_div.den_mag) << SHIFT;
    div_nxt = in_div;
    if (in_div.rem >= trial) begin
      div_nxt.rem      = in_div.rem - trial;
      div_nxt.q[SHIFT] = 1'b1;
    end
  end

  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      div_r <= div_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_div   = div_r;

endmodule

### rtl/pwl_out.sv
// Result stage: sign, clamp to 0..100, flat segment override, output register.
// Depends on pwl_pkg.
module pwl_out import pwl_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  div_t in_div,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_res
);

  logic valid_r;
  res_t res_r;
  res_t res_nxt;

  always_comb begin
    res_nxt.segment      = in_div.lo;
    res_nxt.flat_segment = in_div.flat;
    if (in_div.flat) begin
      // zero-width segment: lower percentage, clamped at 100
      res_nxt.clamped = (in_div.y0 > X_W'(PCT_MAX));
      res_nxt.percent = res_nxt.clamped ? PCT_MAX : in_div.y0[PCT_W-1:0];
    end else if (in_div.neg) begin
      // negative quotient; magnitude below one truncates to zero unflagged
      res_nxt.clamped = (in_div.q != '0);
      res_nxt.percent = PCT_MIN;
    end else begin
      // quotient above 100 clamps to 100; a set top bit means far above range
      res_nxt.clamped = (in_div.q > Q_W'(PCT_MAX));
      res_nxt.percent = res_nxt.clamped ? PCT_MAX : in_div.q[PCT_W-1:0];
    end
  end

  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

### rtl/piecewise_linear_calibration_core.sv
// Piecewise linear calibration core: 8-bit reading in, clamped percent out.
// Pipeline from input beat to result beat: segment select, multiply,
// sum, a row of 8 divide cells (one quotient bit each), result register.
// Throughput one beat per cycle; every stage holds its own beat under backpressure.
// Reset (rst_n low, synchronous) empties the pipeline and loads the default points.
// Depends on pwl_pkg, pwl_ifs, pwl_seg, pwl_arith, pwl_div_cell, pwl_out.
module piecewise_linear_calibration_core import pwl_pkg::*; #(
  parameter int unsigned POINTS = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  pwl_in_if.sink       in_bus,
  pwl_out_if.source    out_bus,
  pwl_cfg_if.sink      cfg_bus
);

  logic [REG_W-1:0] res_pts_r;
  logic [REG_W-1:0] pct_pts_r;

  logic seg_valid;
  logic seg_ready;
  seg_t seg;

  logic div_valid [0:Q_W];
  logic div_ready [0:Q_W];
  div_t div_chain [0:Q_W];

  res_t res;

  // configuration registers, always ready
  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_pts_r <= RES_PTS_RST;
      pct_pts_r <= PCT_PTS_RST;
    end else if (cfg_bus.valid) begin
      unique case (cfg_reg_t'(cfg_bus.index))
        REG_RES_POINTS: res_pts_r <= cfg_bus.data;
        REG_PCT_POINTS: pct_pts_r <= cfg_bus.data;
        default: ;
      endcase
    end
  end

  // breakpoint search
  pwl_seg #(
    .POINTS (POINTS)
  ) u_seg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_pts   (res_pts_r),
    .pct_pts   (pct_pts_r),
    .in_valid  (in_bus.valid),
    .in_ready  (in_bus.ready),
    .in_x      (in_bus.resistance),
    .out_valid (seg_valid),
    .out_ready (seg_ready),
    .out_seg   (seg)
  );

  // numerator and denominator
  pwl_arith u_arith (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (seg_valid),
    .in_ready  (seg_ready),
    .in_seg    (seg),
    .out_valid (div_valid[0]),
    .out_ready (div_ready[0]),
    .out_div   (div_chain[0])
  );

  // divider row, most significant quotient bit first
  for (genvar k = 0; k < Q_W; k++) begin : g_div
    pwl_div_cell #(
      .SHIFT (Q_W - 1 - k)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (div_valid[k]),
      .in_ready  (div_ready[k]),
      .in_div    (div_chain[k]),
      .out_valid (div_valid[k+1]),
      .out_ready (div_ready[k+1]),
      .out_div   (div_chain[k+1])
    );
  end

  // clamp and output register
  pwl_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (div_valid[Q_W]),
    .in_ready  (div_ready[Q_W]),
    .in_div    (div_chain[Q_W]),
    .out_valid (out_bus.valid),
    .out_ready (out_bus.ready),
    .out_res   (res)
  );

  assign out_bus.percent      = res.percent;
  assign out_bus.segment      = res.segment;
  assign out_bus.clamped      = res.clamped;
  assign out_bus.flat_segment = res.flat_segment;

endmodule

### rtl/pwl_checker.sv
// Port-level checks for the calibration core, bound onto the top level.
// Depends on pwl_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pwl_checker import pwl_pkg::*; #(
  parameter int unsigned POINTS = 8
) (
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_ready,
  input logic [PCT_W-1:0] percent,
  input logic [SEG_W-1:0] segment,
  input logic             clamped,
  input logic             flat_segment
);

  // a stalled result beat holds
  `PWL_ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(percent) && $stable(segment) && $stable(clamped) && $stable(flat_segment), "result beat changed while stalled")

  // percent never leaves 0..100
  `PWL_ASSERT_CLK(a_pct_range, out_valid |-> percent <= PCT_MAX, "percent above 100")

  // a clamped result sits on one of the rails
  `PWL_ASSERT_CLK(a_clamp_rail, out_valid && clamped |-> percent == PCT_MIN || percent == PCT_MAX, "clamped result not on a rail")

  // segment is a valid lower breakpoint
  `PWL_ASSERT_CLK(a_seg_range, out_valid |-> segment <= SEG_W'(POINTS - 2), "segment index out of range")

  // reset empties the output register
  `PWL_ASSERT_ANY(a_rst_empty, !rst_n |=> !out_valid, "result valid right after reset")

endmodule

bind piecewise_linear_calibration_core pwl_checker #(
  .POINTS (POINTS)
) u_pwl_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_bus.valid),
  .out_ready    (out_bus.ready),
  .percent      (out_bus.percent),
  .segment      (out_bus.segment),
  .clamped      (out_bus.clamped),
  .flat_segment (out_bus.flat_segment)
);
